// ===== src/ssbm_pkg.sv =====
// ----------------------------------------------------------------------------
// ssbm_pkg: shared types and constants of the subset site and block mask builder
// Result record layout, result kinds, status codes, register indexes and
// default sizes used by the channel interfaces, the core and the result queue.
// ----------------------------------------------------------------------------
package ssbm_pkg;

	localparam int INNER_LENGTH_DEF = 8;
	localparam int MAX_SITES_DEF    = 65536;

	localparam int COLOR_W     = 8;
	localparam int NUM_SUBS_W  = 9;
	localparam int SITE_IDX_W  = 16;
	localparam int BLOCK_IDX_W = 13;
	localparam int MASK_W      = 8;
	localparam int COUNT_W     = 17;
	localparam int SITE_OUT_W  = 17;
	localparam int BLOCK_OUT_W = 14;

	localparam int MAX_RESULTS = 3;
	localparam int QDEPTH      = 8;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	localparam logic [COLOR_W-1:0]    TARGET_RESET = '0;
	localparam logic [NUM_SUBS_W-1:0] NUM_SUBS_RESET = NUM_SUBS_W'(2);

	typedef enum logic [1:0] {
		KIND_SITE,
		KIND_BLOCK,
		KIND_SUMMARY
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_COLOR_RANGE,
		ST_START_UNALIGNED,
		ST_END_UNALIGNED
	} status_t;

	typedef enum logic [0:0] {
		REG_TARGET_SUBSET,
		REG_NUM_SUBSETS
	} cfg_reg_t;

	typedef struct packed {
		kind_t                          kind;
		logic [SITE_IDX_W-1:0]          site_index;
		logic [BLOCK_IDX_W-1:0]         block_index;
		logic [MASK_W-1:0]              block_mask;
		logic [COUNT_W-1:0]             member_count;
		logic                           ordered;
		logic signed [SITE_OUT_W-1:0]   start_site;
		logic signed [SITE_OUT_W-1:0]   end_site;
		logic signed [BLOCK_OUT_W-1:0]  start_block;
		logic signed [BLOCK_OUT_W-1:0]  end_block;
		status_t                        status;
		logic                           last_result;
	} res_t;

	typedef struct packed {
		logic [1:0]                 n;
		res_t [MAX_RESULTS-1:0]     rec;
	} push_t;

	typedef struct packed {
		logic                     we;
		cfg_reg_t                 index;
		logic [NUM_SUBS_W-1:0]    data;
	} cfg_wr_t;

endpackage

// ===== src/ssbm_ifs.sv =====
// ----------------------------------------------------------------------------
// ssbm channel interfaces
// Valid/ready channels for site colors, result records and register writes.
// ----------------------------------------------------------------------------
interface ssbm_in_if
	import ssbm_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [COLOR_W-1:0] site_color;
	logic               last_site;

	modport source (output valid, site_color, last_site, input ready);
	modport sink (input valid, site_color, last_site, output ready);
endinterface

interface ssbm_out_if
	import ssbm_pkg::*;
();
	logic                          valid;
	logic                          ready;
	kind_t                         kind;
	logic [SITE_IDX_W-1:0]         site_index;
	logic [BLOCK_IDX_W-1:0]        block_index;
	logic [MASK_W-1:0]             block_mask;
	logic [COUNT_W-1:0]            member_count;
	logic                          ordered;
	logic signed [SITE_OUT_W-1:0]  start_site;
	logic signed [SITE_OUT_W-1:0]  end_site;
	logic signed [BLOCK_OUT_W-1:0] start_block;
	logic signed [BLOCK_OUT_W-1:0] end_block;
	status_t                       status;
	logic                          last_result;

	modport source (output valid, kind, site_index, block_index, block_mask, member_count,
		ordered, start_site, end_site, start_block, end_block, status, last_result,
		input ready);
	modport sink (input valid, kind, site_index, block_index, block_mask, member_count,
		ordered, start_site, end_site, start_block, end_block, status, last_result,
		output ready);
endinterface

interface ssbm_cfg_if
	import ssbm_pkg::*;
();
	logic                  valid;
	logic                  ready;
	cfg_reg_t              index;
	logic [NUM_SUBS_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== src/ssbm_core.sv =====
// ----------------------------------------------------------------------------
// ssbm_core: per-site membership tracking
// Holds the configuration and pass state and forms combinationally, for each
// accepted site, the site entry, block entry and summary records it calls for.
// ----------------------------------------------------------------------------
module ssbm_core
	import ssbm_pkg::*;
#(
	parameter int INNER_LENGTH = INNER_LENGTH_DEF,
	parameter int MAX_SITES    = MAX_SITES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_wr_t            cfg_wr,
	input  logic               accept,
	input  logic [COLOR_W-1:0] site_color,
	input  logic               last_site,
	output push_t              push
);

	localparam int SW     = $clog2(MAX_SITES);
	localparam int CW     = $clog2(MAX_SITES + 1);
	localparam int IW     = $clog2(INNER_LENGTH);
	localparam int BW_RAW = $clog2((MAX_SITES - 1) / INNER_LENGTH + 1);
	localparam int BW     = (BW_RAW < 1) ? 1 : BW_RAW;

	logic [COLOR_W-1:0]      target_q;
	logic [NUM_SUBS_W-1:0]   num_subs_q;

	logic [SW-1:0]           site_q;
	logic [IW-1:0]           inner_q;
	logic [BW-1:0]           blk_q;
	logic [INNER_LENGTH-1:0] mask_q;
	logic [CW-1:0]           count_q;
	logic [SW-1:0]           first_site_q;
	logic [IW-1:0]           first_inner_q;
	logic [BW-1:0]           first_blk_q;
	logic [SW-1:0]           prev_site_q;
	logic [IW-1:0]           prev_inner_q;
	logic [BW-1:0]           prev_blk_q;
	logic                    contig_q;
	logic                    cerr_q;

	logic                    member;
	logic                    last;
	logic                    blk_end;
	logic                    cerr_new;
	logic                    contig_new;
	logic [INNER_LENGTH-1:0] mask_new;
	logic [CW-1:0]           count_new;
	logic [SW-1:0]           first_site_new;
	logic [IW-1:0]           first_inner_new;
	logic [BW-1:0]           first_blk_new;
	logic [SW-1:0]           prev_site_new;
	logic [IW-1:0]           prev_inner_new;
	logic [BW-1:0]           prev_blk_new;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q   <= TARGET_RESET;
			num_subs_q <= NUM_SUBS_RESET;
		end else if (cfg_wr.we) begin
			unique case (cfg_wr.index)
				REG_TARGET_SUBSET: target_q <= cfg_wr.data[COLOR_W-1:0];
				REG_NUM_SUBSETS:   num_subs_q <= cfg_wr.data;
				default:           target_q <= target_q;
			endcase
		end
	end

	// next pass state
	always_comb begin
		member   = (site_color == target_q);
		last     = last_site || (site_q == SW'(MAX_SITES - 1));
		blk_end  = (inner_q == IW'(INNER_LENGTH - 1));
		cerr_new = cerr_q || ({1'b0, site_color} >= num_subs_q);

		contig_new      = contig_q;
		mask_new        = mask_q;
		count_new       = count_q;
		first_site_new  = first_site_q;
		first_inner_new = first_inner_q;
		first_blk_new   = first_blk_q;
		prev_site_new   = prev_site_q;
		prev_inner_new  = prev_inner_q;
		prev_blk_new    = prev_blk_q;

		if (member) begin
			if ((count_q != '0) &&
			    ({1'b0, site_q} != ({1'b0, prev_site_q} + (SW+1)'(1)))) begin
				contig_new = 1'b0;
			end
			if (count_q == '0) begin
				first_site_new  = site_q;
				first_inner_new = inner_q;
				first_blk_new   = blk_q;
			end
			prev_site_new  = site_q;
			prev_inner_new = inner_q;
			prev_blk_new   = blk_q;
			count_new      = count_q + CW'(1);
			mask_new       = mask_q | (INNER_LENGTH'(1) << inner_q);
		end
	end

	// result records
	always_comb begin
		logic    ord;
		status_t st;
		res_t    r_site;
		res_t    r_blk;
		res_t    r_sum;
		logic [1:0] n;

		ord = (count_new != '0) && contig_new;
		st  = ST_OK;
		if (ord) begin
			if (first_inner_new != '0) begin
				st = ST_START_UNALIGNED;
			end else if (prev_inner_new != IW'(INNER_LENGTH - 1)) begin
				st = ST_END_UNALIGNED;
			end
		end
		if (cerr_new) begin
			st = ST_COLOR_RANGE;
		end

		r_site            = '0;
		r_site.kind       = KIND_SITE;
		r_site.site_index = SITE_IDX_W'(site_q);

		r_blk             = '0;
		r_blk.kind        = KIND_BLOCK;
		r_blk.block_index = BLOCK_IDX_W'(blk_q);
		r_blk.block_mask  = MASK_W'(mask_new);

		r_sum              = '0;
		r_sum.kind         = KIND_SUMMARY;
		r_sum.member_count = COUNT_W'(count_new);
		r_sum.ordered      = ord;
		r_sum.status       = st;
		r_sum.start_site   = ord ? SITE_OUT_W'(first_site_new) : '1;
		r_sum.end_site     = ord ? SITE_OUT_W'(prev_site_new) : '1;
		r_sum.start_block  = (ord && st == ST_OK) ? BLOCK_OUT_W'(first_blk_new) : '1;
		r_sum.end_block    = (ord && st == ST_OK) ? BLOCK_OUT_W'(prev_blk_new) : '1;

		push.rec = '0;
		n        = 2'd0;
		if (member) begin
			push.rec[n] = r_site;
			n           = n + 2'd1;
		end
		if ((blk_end || last) && (mask_new != '0)) begin
			push.rec[n] = r_blk;
			n           = n + 2'd1;
		end
		if (last) begin
			push.rec[n] = r_sum;
			n           = n + 2'd1;
		end
		for (int i = 0; i < MAX_RESULTS; i++) begin
			push.rec[i].last_result = (2'(i + 1) == n);
		end
		push.n = accept ? n : 2'd0;
	end

	// pass state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			site_q        <= '0;
			inner_q       <= '0;
			blk_q         <= '0;
			mask_q        <= '0;
			count_q       <= '0;
			first_site_q  <= '0;
			first_inner_q <= '0;
			first_blk_q   <= '0;
			prev_site_q   <= '0;
			prev_inner_q  <= '0;
			prev_blk_q    <= '0;
			contig_q      <= 1'b1;
			cerr_q        <= 1'b0;
		end else if (accept) begin
			if (last) begin
				site_q        <= '0;
				inner_q       <= '0;
				blk_q         <= '0;
				mask_q        <= '0;
				count_q       <= '0;
				first_site_q  <= '0;
				first_inner_q <= '0;
				first_blk_q   <= '0;
				prev_site_q   <= '0;
				prev_inner_q  <= '0;
				prev_blk_q    <= '0;
				contig_q      <= 1'b1;
				cerr_q        <= 1'b0;
			end else begin
				site_q        <= site_q + SW'(1);
				if (blk_end) begin
					inner_q <= '0;
					blk_q   <= blk_q + BW'(1);
					mask_q  <= '0;
				end else begin
					inner_q <= inner_q + IW'(1);
					mask_q  <= mask_new;
				end
				count_q       <= count_new;
				first_site_q  <= first_site_new;
				first_inner_q <= first_inner_new;
				first_blk_q   <= first_blk_new;
				prev_site_q   <= prev_site_new;
				prev_inner_q  <= prev_inner_new;
				prev_blk_q    <= prev_blk_new;
				contig_q      <= contig_new;
				cerr_q        <= cerr_new;
			end
		end
	end

`ifndef SYNTHESIS
	a_pass_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> (site_q == '0) && (count_q == '0) && contig_q && !cerr_q)
		else $error("pass state not cleared after final site");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, count_q} <= (CW+1)'(site_q))
		else $error("member count exceeds sites seen");
	a_inner_track: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !last && !blk_end |=> inner_q == $past(inner_q) + IW'(1))
		else $error("inner position lost step");
`endif

endmodule

// ===== src/ssbm_queue.sv =====
// ----------------------------------------------------------------------------
// ssbm_queue: result record queue
// Takes up to three records per cycle from the core and hands them to the
// output channel one per transfer, in order.
// ----------------------------------------------------------------------------
module ssbm_queue
	import ssbm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  space,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  out_rec
);

	res_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign space     = (count_q <= QCNT_W'(QDEPTH - MAX_RESULTS));
	assign out_rec   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RESULTS; i++) begin
			if (2'(i) < push.n) begin
				mem_q[wr_ptr_q + QPTR_W'(i)] <= push.rec[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push.n) - QCNT_W'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("result queue overflow");
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		pop && push.n == 2'd0 |=> count_q == $past(count_q) - QCNT_W'(1))
		else $error("result queue count off after transfer");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == QCNT_W'(QDEPTH)) || (QPTR_W'(count_q) == QPTR_W'(wr_ptr_q - rd_ptr_q)))
		else $error("result queue pointers disagree with count");
`endif

endmodule

// ===== src/subset_site_and_block_mask_builder_top.sv =====
// ----------------------------------------------------------------------------
// subset_site_and_block_mask_builder_top: subset site and block mask builder
// Site colors come in on in_ch in linear site order, one per transfer, with
// last_site marking the final site of the lattice. For the subset chosen by
// register target_subset the block sends on out_ch a site record for every
// member site, a block record with the member mask at the end of every block
// of INNER_LENGTH sites that has members, and a summary after the final site.
// Registers are written on cfg (index 0 target_subset, index 1 num_subsets);
// the user must do so only while no work is in flight, as the block does not
// enforce it. cfg is always ready. One site is taken per cycle while in_ch is
// ready; each site makes zero to three records, which leave on out_ch one per
// cycle while out_ch is ready. Records wait in an eight-entry queue; in_ch
// stays ready while at least three entries are free, so a stalled receiver
// holds back input only once the queue fills, and the rate is then set by how
// fast out_ch drains it. Reset clears the pass state, empties the queue and
// restores the register defaults (target 0, two legal colors). After a summary
// the pass state is clear for the next lattice.
// ----------------------------------------------------------------------------
module subset_site_and_block_mask_builder_top
	import ssbm_pkg::*;
#(
	parameter int INNER_LENGTH = INNER_LENGTH_DEF,
	parameter int MAX_SITES    = MAX_SITES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ssbm_in_if.sink    in_ch,
	ssbm_out_if.source out_ch,
	ssbm_cfg_if.sink   cfg
);

	cfg_wr_t cfg_wr;
	push_t   push;
	logic    space;
	logic    accept;
	res_t    out_rec;

	assign cfg.ready    = 1'b1;
	assign cfg_wr.we    = cfg.valid;
	assign cfg_wr.index = cfg.index;
	assign cfg_wr.data  = cfg.data;

	assign in_ch.ready = space;
	assign accept      = in_ch.valid && space;

	ssbm_core #(
		.INNER_LENGTH (INNER_LENGTH),
		.MAX_SITES    (MAX_SITES)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr     (cfg_wr),
		.accept     (accept),
		.site_color (in_ch.site_color),
		.last_site  (in_ch.last_site),
		.push       (push)
	);

	ssbm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space     (space),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_rec   (out_rec)
	);

	assign out_ch.kind         = out_rec.kind;
	assign out_ch.site_index   = out_rec.site_index;
	assign out_ch.block_index  = out_rec.block_index;
	assign out_ch.block_mask   = out_rec.block_mask;
	assign out_ch.member_count = out_rec.member_count;
	assign out_ch.ordered      = out_rec.ordered;
	assign out_ch.start_site   = out_rec.start_site;
	assign out_ch.end_site     = out_rec.end_site;
	assign out_ch.start_block  = out_rec.start_block;
	assign out_ch.end_block    = out_rec.end_block;
	assign out_ch.status       = out_rec.status;
	assign out_ch.last_result  = out_rec.last_result;

endmodule

// ===== bench/subset_site_and_block_mask_builder_top_tb.sv =====
// ----------------------------------------------------------------------------
// subset_site_and_block_mask_builder_top_tb: self-checking bench for the builder
// Site colors go in as passes of random and directed shape, with register
// changes between passes. Every transfer is predicted in the bench, and each
// record that comes out is checked field by field against the oldest one
// still due. Both channels idle at random, and the receiver also holds off
// long enough to fill the record queue.
// ----------------------------------------------------------------------------
module subset_site_and_block_mask_builder_top_tb;
	import ssbm_pkg::*;

	localparam int INNER       = INNER_LENGTH_DEF;
	localparam int SITE_LIMIT  = MAX_SITES_DEF;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int RANDOM_SITES = 340;

	logic clk;
	logic arst_n;

	ssbm_in_if  in_ch();
	ssbm_out_if out_ch();
	ssbm_cfg_if cfg();

	subset_site_and_block_mask_builder_top #(
		.INNER_LENGTH(INNER),
		.MAX_SITES(SITE_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg(cfg)
	);

	// register copies
	logic [COLOR_W-1:0]    cfg_target;
	logic [NUM_SUBS_W-1:0] cfg_num_subsets;

	// pass state
	int unsigned       pass_site;
	logic [MASK_W-1:0] pass_mask;
	int unsigned       pass_members;
	int unsigned       run_first;
	int unsigned       run_last;
	bit                run_unbroken;
	bit                pass_bad_color;

	res_t mask_records_due[$];

	int  fail_count;
	int  sites_sent;
	int  cycle_count;
	int  hold_left;
	bit  quiet;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void clear_pass();
		pass_site      = 0;
		pass_mask      = '0;
		pass_members   = 0;
		run_first      = 0;
		run_last       = 0;
		run_unbroken   = 1'b1;
		pass_bad_color = 1'b0;
	endfunction

	// records caused by one site transfer
	function automatic void build_site_records(input logic [COLOR_W-1:0] color, input logic last);
		res_t        rec;
		res_t        batch[$];
		bit          fin;
		bit          ord;
		int unsigned inner;
		status_t     st;
		fin = last || (pass_site >= SITE_LIMIT - 1);
		inner = pass_site % INNER;
		if ({1'b0, color} >= cfg_num_subsets)
			pass_bad_color = 1'b1;
		if (color == cfg_target) begin
			if (pass_members > 0 && pass_site != run_last + 1)
				run_unbroken = 1'b0;
			if (pass_members == 0)
				run_first = pass_site;
			run_last = pass_site;
			pass_members++;
			if (inner < MASK_W)
				pass_mask[inner] = 1'b1;
			rec = '0;
			rec.kind = KIND_SITE;
			rec.site_index = SITE_IDX_W'(pass_site);
			batch.push_back(rec);
		end
		if (inner == INNER - 1 || fin) begin
			if (pass_mask != '0) begin
				rec = '0;
				rec.kind = KIND_BLOCK;
				rec.block_index = BLOCK_IDX_W'(pass_site / INNER);
				rec.block_mask = pass_mask;
				batch.push_back(rec);
			end
			pass_mask = '0;
		end
		if (fin) begin
			ord = (pass_members > 0) && run_unbroken;
			st = ST_OK;
			if (ord) begin
				if (run_first % INNER != 0)
					st = ST_START_UNALIGNED;
				else if (run_last % INNER != INNER - 1)
					st = ST_END_UNALIGNED;
			end
			if (pass_bad_color)
				st = ST_COLOR_RANGE;
			rec = '0;
			rec.kind = KIND_SUMMARY;
			rec.member_count = COUNT_W'(pass_members);
			rec.ordered = ord;
			rec.start_site = ord ? SITE_OUT_W'(run_first) : '1;
			rec.end_site = ord ? SITE_OUT_W'(run_last) : '1;
			rec.start_block = (ord && st == ST_OK) ? BLOCK_OUT_W'(run_first / INNER) : '1;
			rec.end_block = (ord && st == ST_OK) ? BLOCK_OUT_W'(run_last / INNER) : '1;
			rec.status = st;
			batch.push_back(rec);
			clear_pass();
		end else begin
			pass_site++;
		end
		if (batch.size() > 0)
			batch[batch.size() - 1].last_result = 1'b1;
		foreach (batch[i])
			mask_records_due.push_back(batch[i]);
	endfunction

	task automatic check_field(input string name, input logic signed [31:0] want,
		input logic signed [31:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	task automatic check_record();
		res_t want;
		if (mask_records_due.size() == 0) begin
			fail_count++;
			$display("%0t: record with none due, expected none actual kind %0d",
				$time, out_ch.kind);
		end else begin
			want = mask_records_due.pop_front();
			check_field("kind", want.kind, out_ch.kind);
			check_field("site_index", want.site_index, out_ch.site_index);
			check_field("block_index", want.block_index, out_ch.block_index);
			check_field("block_mask", want.block_mask, out_ch.block_mask);
			check_field("member_count", want.member_count, out_ch.member_count);
			check_field("ordered", want.ordered, out_ch.ordered);
			check_field("start_site", want.start_site, out_ch.start_site);
			check_field("end_site", want.end_site, out_ch.end_site);
			check_field("start_block", want.start_block, out_ch.start_block);
			check_field("end_block", want.end_block, out_ch.end_block);
			check_field("status", want.status, out_ch.status);
			check_field("last_result", want.last_result, out_ch.last_result);
		end
	endtask

	always @(posedge clk) begin
		if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
			check_record();
	end

	// receiver: random stalls, plus long hold-offs on request
	initial begin
		int stall;
		stall = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ch.ready <= 1'b0;
				hold_left--;
			end else if (quiet) begin
				out_ch.ready <= 1'b1;
			end else if (stall > 0) begin
				out_ch.ready <= 1'b0;
				stall--;
			end else begin
				out_ch.ready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	task automatic send_site(input logic [COLOR_W-1:0] color, input logic last);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.site_color <= color;
		in_ch.last_site <= last;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		build_site_records(color, last);
		sites_sent++;
	endtask

	// stop sending and wait until every record has come out
	task automatic settle_block();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (mask_records_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [NUM_SUBS_W-1:0] val);
		settle_block();
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		if (idx == REG_TARGET_SUBSET)
			cfg_target = val[COLOR_W-1:0];
		else
			cfg_num_subsets = val;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic set_idling(input bit q);
		@(negedge clk);
		in_ch.valid <= 1'b0;
		@(posedge clk);
		quiet = q;
	endtask

	function automatic logic [COLOR_W-1:0] other_color();
		int c;
		if (cfg_num_subsets <= 255 && $urandom_range(0, 59) == 0) begin
			c = $urandom_range(cfg_num_subsets, 255);
			if (c != cfg_target)
				return COLOR_W'(c);
		end
		for (int k = 0; k < 8; k++) begin
			c = $urandom_range(0, cfg_num_subsets - 1);
			if (c != cfg_target)
				return COLOR_W'(c);
		end
		do c = $urandom_range(0, 255); while (c == cfg_target);
		return COLOR_W'(c);
	endfunction

	task automatic run_random_pass(input int len);
		logic [127:0] members;
		int style;
		int lo;
		int hi;
		int p;
		members = '0;
		style = $urandom_range(0, 9);
		if (style <= 5 || style >= 8) begin
			lo = $urandom_range(0, len - 1);
			hi = $urandom_range(lo, len - 1);
			if (style <= 2) begin
				lo = lo - lo % INNER;
				hi = hi | (INNER - 1);
				if (hi >= len)
					hi = len - 1;
			end
			for (int i = lo; i <= hi; i++)
				members[i] = 1'b1;
			if (style >= 8 && hi - lo >= 2)
				members[$urandom_range(lo + 1, hi - 1)] = 1'b0;
		end else if (style == 6) begin
			p = $urandom_range(10, 90);
			for (int i = 0; i < len; i++)
				members[i] = ($urandom_range(0, 99) < p);
		end
		for (int i = 0; i < len; i++)
			send_site(members[i] ? cfg_target : other_color(), i == len - 1);
	endtask

	task automatic test_default_registers();
		for (int i = 0; i < INNER; i++)
			send_site(8'd0, i == INNER - 1);
	endtask

	task automatic test_special_cases();
		// out-of-range target color, also unaligned
		write_reg(REG_TARGET_SUBSET, 9'd200);
		write_reg(REG_NUM_SUBSETS, 9'd4);
		send_site(8'd1, 1'b0);
		send_site(8'd200, 1'b0);
		send_site(8'd200, 1'b0);
		send_site(8'd3, 1'b1);
		// empty subset
		write_reg(REG_TARGET_SUBSET, 9'd1);
		write_reg(REG_NUM_SUBSETS, 9'd256);
		send_site(8'd0, 1'b0);
		send_site(8'd2, 1'b1);
		// run ends short of a block end
		send_site(8'd1, 1'b0);
		send_site(8'd1, 1'b0);
		send_site(8'd1, 1'b1);
		// run starts off a block boundary
		send_site(8'd0, 1'b0);
		send_site(8'd1, 1'b0);
		send_site(8'd1, 1'b1);
		// hole between members
		send_site(8'd1, 1'b0);
		send_site(8'd0, 1'b0);
		send_site(8'd1, 1'b1);
		// single-site lattice at the top color
		write_reg(REG_TARGET_SUBSET, 9'd255);
		send_site(8'd255, 1'b1);
		// one legal color only
		write_reg(REG_TARGET_SUBSET, 9'd0);
		write_reg(REG_NUM_SUBSETS, 9'd1);
		send_site(8'd0, 1'b0);
		send_site(8'd255, 1'b1);
	endtask

	task automatic test_output_stall();
		write_reg(REG_TARGET_SUBSET, 9'd3);
		@(posedge clk);
		hold_left = 300;
		for (int i = 0; i < 40; i++)
			send_site(8'd3, i == 39);
		settle_block();
		for (int i = 0; i < 12; i++)
			send_site(i % 3 == 0 ? 8'd3 : 8'd5, i == 11);
	endtask

	task automatic test_random_passes();
		int phase;
		int first_sent;
		int r;
		int tgt;
		phase = 0;
		first_sent = sites_sent;
		while (sites_sent - first_sent < RANDOM_SITES) begin
			if (phase % 4 == 0) begin
				case (phase / 4)
					0: begin
						tgt = 0;
						write_reg(REG_NUM_SUBSETS, 9'd1);
					end
					1: begin
						tgt = 255;
						write_reg(REG_NUM_SUBSETS, 9'd256);
					end
					default: begin
						tgt = $urandom_range(0, 255);
						r = $urandom_range(0, 3);
						if (r <= 1)
							write_reg(REG_NUM_SUBSETS, 9'd256);
						else if (r == 2)
							write_reg(REG_NUM_SUBSETS, NUM_SUBS_W'($urandom_range(1, 256)));
						else
							write_reg(REG_NUM_SUBSETS, NUM_SUBS_W'(tgt + 1));
					end
				endcase
				write_reg(REG_TARGET_SUBSET, NUM_SUBS_W'(tgt));
				set_idling(phase % 12 == 8);
			end
			r = $urandom_range(0, 9);
			run_random_pass(r < 8 ? $urandom_range(1, 24) : $urandom_range(25, 96));
			phase++;
		end
		set_idling(1'b0);
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.site_color = '0;
		in_ch.last_site = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_TARGET_SUBSET;
		cfg.data = '0;
		cfg_target = TARGET_RESET;
		cfg_num_subsets = NUM_SUBS_RESET;
		fail_count = 0;
		sites_sent = 0;
		cycle_count = 0;
		hold_left = 0;
		quiet = 1'b0;
		clear_pass();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_default_registers();
		test_special_cases();
		test_output_stall();
		test_random_passes();
		settle_block();
		repeat (16) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
